@@ sv/lbps_pkg.sv @@
// Package for the LED blink pattern sequencer.
// Holds the transaction payload types, register indexes and mode codes.
// No dependencies.
`default_nettype none

package lbps_pkg;

	localparam int SHOT_FIELDS = 6;
	localparam int FIELD_BITS  = 16;
	localparam int REP_REGS    = 6;

	localparam logic [2:0] REG_MODE     = 3'd0;
	localparam logic [2:0] REG_INVERT   = 3'd1;
	localparam logic [2:0] REG_REP_ON1  = 3'd2;
	localparam logic [2:0] REG_REP_OFF3 = 3'd7;

	localparam logic [2:0] MODE_OFF     = 3'd0;
	localparam logic [2:0] MODE_ON      = 3'd1;
	localparam logic [2:0] MODE_REP1    = 3'd2;
	localparam logic [2:0] MODE_REP2    = 3'd3;
	localparam logic [2:0] MODE_REP3    = 3'd4;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	typedef struct packed {
		logic        op;
		logic [2:0]  shot_count;
		logic [15:0] dur_a;
		logic [15:0] dur_b;
		logic [15:0] dur_c;
		logic [15:0] dur_d;
		logic [15:0] dur_e;
		logic [15:0] dur_f;
	} in_item_t;

	typedef struct packed {
		logic led_pin;
		logic shot_active;
	} out_item_t;

endpackage

`default_nettype wire

@@ sv/led_blink_pattern_sequencer.sv @@
// LED blink pattern sequencer top level.
// Uses lbps_pkg for payload types, register indexes and mode codes.
//
// Usage: each input transaction is either a time tick (one millisecond) or a
// one-shot load carrying up to six on/off durations. Every input transaction
// yields exactly one output transaction with the pin level and a flag that
// is high while a one-shot decides the level. Registers (mode, invert and
// the six repeat durations) are written over cfg_we/cfg_index/cfg_data
// while no transaction is in flight; the user must keep to this, as the
// block does not enforce it. An accepted input is registered, evaluated
// against the time base and one-shot breakpoints, and registered into
// out_valid/out_data when it advances; out_stall can hold it in between.
// Throughput: one transaction per cycle unless out_stall holds the output;
// the time base and breakpoint compares lie between the input and result
// registers; one-shot breakpoint sums are formed before the input register.
// Reset clears the mode, invert, repeat durations, time base and one-shot
// length; no transaction is pending. When out_stall holds the output, the
// input register still takes one more transaction, then in_stall rises.
`default_nettype none

module led_blink_pattern_sequencer #(
	parameter int MAX_STEPS = 6,
	parameter int DUR_BITS  = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire lbps_pkg::in_item_t in_data,
	output logic                 out_valid,
	input  wire                  out_stall,
	output lbps_pkg::out_item_t  out_data,
	input  wire                  cfg_we,
	input  wire [2:0]            cfg_index,
	input  wire [15:0]           cfg_data
);

	localparam int LIMIT = (MAX_STEPS < lbps_pkg::SHOT_FIELDS) ? MAX_STEPS
		: lbps_pkg::SHOT_FIELDS;
	localparam int LW = $clog2(LIMIT + 1);
	localparam int MW = DUR_BITS + 3;
	localparam int EW = DUR_BITS + 4;
	localparam logic [EW-1:0] ELAPSED_MAX = '1;

	logic [2:0]           mode_q;
	logic                 invert_q;
	logic [15:0]          rep_dur_q  [lbps_pkg::REP_REGS];
	logic [MW-1:0]        rep_mark_q [lbps_pkg::REP_REGS];

	logic [EW-1:0]        elapsed_q;
	logic [MW-1:0]        shot_marks_q [LIMIT];
	logic [LW-1:0]        shot_len_q;

	logic                 valid_s1;
	logic                 op_s1;
	logic [LW-1:0]        len_s1;
	logic [MW-1:0]        marks_s1 [LIMIT];

	logic                 out_valid_q;
	lbps_pkg::out_item_t  out_data_q;

	logic                 in_accept;
	logic                 advance;
	logic                 rep_mode;
	logic [2:0]           rep_sel;

	logic [MW-1:0]        dur_ext   [lbps_pkg::SHOT_FIELDS];
	logic [MW-1:0]        prefix    [LIMIT];
	logic [MW-1:0]        marks_in  [LIMIT];
	logic [LW-1:0]        len_in;
	logic [LW-1:0]        count_c;
	logic [MW-1:0]        rep_gap;
	logic                 append;

	logic [EW-1:0]        t_now;
	logic [MW-1:0]        marks_cur [LIMIT];
	logic [LW-1:0]        len_cur;
	logic [MW-1:0]        shot_last;
	logic                 shot_par;
	logic [MW-1:0]        rep_last;
	logic                 rep_par;
	logic [2:0]           rep_n;
	logic                 lit;
	logic                 active;
	logic [EW-1:0]        elapsed_d;
	logic [LW-1:0]        shot_len_d;

	function automatic logic [MW-1:0] dur_mask(input logic [15:0] v);
		logic [DUR_BITS-1:0] d;
		d = DUR_BITS'(v);
		return MW'(d);
	endfunction

	assign rep_mode  = (mode_q >= lbps_pkg::MODE_REP1) && (mode_q <= lbps_pkg::MODE_REP3);
	assign rep_sel   = cfg_index - lbps_pkg::REG_REP_ON1;
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// breakpoints of a one-shot load, formed ahead of the input register
	always_comb begin
		dur_ext[0] = dur_mask(in_data.dur_a);
		dur_ext[1] = dur_mask(in_data.dur_b);
		dur_ext[2] = dur_mask(in_data.dur_c);
		dur_ext[3] = dur_mask(in_data.dur_d);
		dur_ext[4] = dur_mask(in_data.dur_e);
		dur_ext[5] = dur_mask(in_data.dur_f);
		count_c = (in_data.shot_count > 3'(LIMIT)) ? LW'(LIMIT) : LW'(in_data.shot_count);
		unique case (mode_q)
			lbps_pkg::MODE_REP1: rep_gap = dur_mask(rep_dur_q[1]);
			lbps_pkg::MODE_REP2: rep_gap = dur_mask(rep_dur_q[3]);
			lbps_pkg::MODE_REP3: rep_gap = dur_mask(rep_dur_q[5]);
			default:             rep_gap = '0;
		endcase
		append = count_c[0] && rep_mode && (int'(count_c) < LIMIT);
		prefix[0] = dur_ext[0];
		for (int i = 1; i < LIMIT; i++) begin
			prefix[i] = prefix[i-1] + dur_ext[i];
		end
		marks_in[0] = prefix[0];
		for (int i = 1; i < LIMIT; i++) begin
			marks_in[i] = (append && int'(count_c) == i) ? prefix[i-1] + rep_gap : prefix[i];
		end
		len_in = append ? count_c + LW'(1) : count_c;
	end

	// evaluate one transaction against the time base
	always_comb begin
		t_now = (op_s1 == lbps_pkg::OP_LOAD) ? '0
			: (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + EW'(1);
		len_cur = (op_s1 == lbps_pkg::OP_LOAD) ? len_s1 : shot_len_q;
		for (int i = 0; i < LIMIT; i++) begin
			marks_cur[i] = (op_s1 == lbps_pkg::OP_LOAD) ? marks_s1[i] : shot_marks_q[i];
		end
		shot_last = '0;
		shot_par  = 1'b0;
		for (int i = 0; i < LIMIT; i++) begin
			if (LW'(i + 1) == len_cur) begin
				shot_last = marks_cur[i];
			end
			if (LW'(i) < len_cur && EW'(marks_cur[i]) <= t_now) begin
				shot_par = !shot_par;
			end
		end
		unique case (mode_q)
			lbps_pkg::MODE_REP1: rep_n = 3'd2;
			lbps_pkg::MODE_REP2: rep_n = 3'd4;
			lbps_pkg::MODE_REP3: rep_n = 3'd6;
			default:             rep_n = 3'd0;
		endcase
		rep_last = '0;
		rep_par  = 1'b0;
		for (int i = 0; i < lbps_pkg::REP_REGS; i++) begin
			if (3'(i + 1) == rep_n) begin
				rep_last = rep_mark_q[i];
			end
			if (3'(i) < rep_n && EW'(rep_mark_q[i]) <= t_now) begin
				rep_par = !rep_par;
			end
		end
		lit        = 1'b0;
		active     = 1'b0;
		elapsed_d  = t_now;
		shot_len_d = len_cur;
		priority if (len_cur != '0) begin
			active = 1'b1;
			if (t_now >= EW'(shot_last)) begin
				shot_len_d = '0;
				elapsed_d  = '0;
			end else begin
				lit = !shot_par;
			end
		end else if (mode_q == lbps_pkg::MODE_ON) begin
			lit = 1'b1;
		end else if (rep_mode) begin
			if (t_now >= EW'(rep_last)) begin
				elapsed_d = '0;
			end else begin
				lit = !rep_par;
			end
		end else begin
			lit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= lbps_pkg::MODE_OFF;
			invert_q    <= 1'b0;
			elapsed_q   <= '0;
			shot_len_q  <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < lbps_pkg::REP_REGS; i++) begin
				rep_dur_q[i]  <= '0;
				rep_mark_q[i] <= '0;
			end
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					lbps_pkg::REG_MODE: begin
						mode_q <= cfg_data[2:0];
						if (cfg_data[2:0] >= lbps_pkg::MODE_REP1
							&& cfg_data[2:0] <= lbps_pkg::MODE_REP3) begin
							elapsed_q <= '0;
						end else begin
							shot_len_q <= '0;
						end
					end
					lbps_pkg::REG_INVERT: begin
						invert_q <= cfg_data[0];
					end
					default: begin
						rep_dur_q[rep_sel] <= cfg_data;
						// shift every running sum from the written entry on
						for (int i = 0; i < lbps_pkg::REP_REGS; i++) begin
							if (3'(i) >= rep_sel) begin
								rep_mark_q[i] <= rep_mark_q[i]
									- dur_mask(rep_dur_q[rep_sel]) + dur_mask(cfg_data);
							end
						end
					end
				endcase
			end else if (advance) begin
				elapsed_q  <= elapsed_d;
				shot_len_q <= shot_len_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1  <= in_data.op;
			len_s1 <= len_in;
			for (int i = 0; i < LIMIT; i++) begin
				marks_s1[i] <= marks_in[i];
			end
		end
		if (advance) begin
			out_data_q.led_pin     <= lit ^ invert_q;
			out_data_q.shot_active <= active;
			if (op_s1 == lbps_pkg::OP_LOAD) begin
				for (int i = 0; i < LIMIT; i++) begin
					shot_marks_q[i] <= marks_s1[i];
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/led_blink_pattern_sequencer_test.sv @@
// Self-checking testbench for led_blink_pattern_sequencer: directed and random ticks and
// one-shot loads under random register settings, with random idling on both channels.
// Depends on lbps_pkg and the led_blink_pattern_sequencer RTL.
module led_blink_pattern_sequencer_test;

	localparam logic [2:0]  MODE_UNUSED_HI = 3'd7;
	localparam logic [19:0] TIME_BASE_MAX  = 20'hFFFFF;
	localparam int          SHOW_LIMIT     = 10;
	localparam int          IN_BITS        = $bits(lbps_pkg::in_item_t);

	typedef enum logic [1:0] {PH_DARK, PH_LIT, PH_DONE} phase_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	lbps_pkg::in_item_t  in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	lbps_pkg::out_item_t out_data;
	logic                cfg_we = 1'b0;
	logic [2:0]          cfg_index = '0;
	logic [15:0]         cfg_data = '0;

	logic [2:0]       mode_q;
	logic             invert_q;
	logic [5:0][15:0] rep_dur_q;
	logic [19:0]      time_base_q;
	logic [5:0][19:0] shot_marks_q;
	int               shot_len_q;

	lbps_pkg::out_item_t pending_q[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_count = 0;
	int result_count = 0;
	int sent_count = 0;
	int load_count = 0;
	int write_count = 0;

	led_blink_pattern_sequencer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic logic repeating();
		return mode_q >= lbps_pkg::MODE_REP1 && mode_q <= lbps_pkg::MODE_REP3;
	endfunction

	// LED starts lit and toggles at every breakpoint reached; done at the last one.
	function automatic phase_t breakpoint_phase(input logic [5:0][19:0] marks, input int n,
			input logic [19:0] t);
		logic lit;
		logic stop;
		int i;
		lit = 1'b1;
		stop = 1'b0;
		if (n == 0 || t >= marks[n - 1])
			return PH_DONE;
		for (i = 0; i < n; i++) begin
			if (!stop) begin
				if (marks[i] > t)
					stop = 1'b1;
				else
					lit = ~lit;
			end
		end
		return lit ? PH_LIT : PH_DARK;
	endfunction

	function automatic lbps_pkg::out_item_t led_predict(input lbps_pkg::in_item_t item);
		logic [5:0][15:0]    durs;
		logic [5:0][19:0]    rep_marks;
		logic [19:0]         t;
		logic [19:0]         sum;
		logic                lit;
		logic                active;
		phase_t              ph;
		lbps_pkg::out_item_t result;
		int                  count;
		int                  pairs;
		int                  n;
		int                  i;
		durs = {item.dur_f, item.dur_e, item.dur_d, item.dur_c, item.dur_b, item.dur_a};
		rep_marks = '0;
		lit = 1'b0;
		active = 1'b0;
		pairs = int'(mode_q) - 1;
		if (item.op == lbps_pkg::OP_LOAD) begin
			count = int'(item.shot_count);
			if (count > lbps_pkg::SHOT_FIELDS)
				count = lbps_pkg::SHOT_FIELDS;
			sum = '0;
			for (i = 0; i < count; i++) begin
				sum = sum + 20'(durs[i]);
				shot_marks_q[i] = sum;
			end
			// odd count: close with the off gap of the last repeat pair
			if (count % 2 == 1 && repeating() && count < lbps_pkg::SHOT_FIELDS) begin
				shot_marks_q[count] = sum + 20'(rep_dur_q[2 * pairs - 1]);
				count++;
			end
			shot_len_q = count;
			t = '0;
		end else begin
			t = (time_base_q < TIME_BASE_MAX) ? time_base_q + 20'd1 : TIME_BASE_MAX;
		end

		if (shot_len_q > 0) begin
			active = 1'b1;
			ph = breakpoint_phase(shot_marks_q, shot_len_q, t);
			if (ph == PH_DONE) begin
				shot_len_q = 0;
				time_base_q = '0;
			end else begin
				lit = (ph == PH_LIT);
				time_base_q = t;
			end
		end else if (mode_q == lbps_pkg::MODE_ON) begin
			lit = 1'b1;
			time_base_q = t;
		end else if (repeating()) begin
			n = 2 * pairs;
			sum = '0;
			for (i = 0; i < n; i++) begin
				sum = sum + 20'(rep_dur_q[i]);
				rep_marks[i] = sum;
			end
			ph = breakpoint_phase(rep_marks, n, t);
			if (ph == PH_DONE) begin
				time_base_q = '0;
			end else begin
				lit = (ph == PH_LIT);
				time_base_q = t;
			end
		end else begin
			time_base_q = t;
		end
		result.led_pin = lit ^ invert_q;
		result.shot_active = active;
		return result;
	endfunction

	always @(posedge clk) begin : check_output
		lbps_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			result_count++;
			if (pending_q.size() == 0) begin
				fail_count++;
				if (fail_count <= SHOW_LIMIT)
					$display("unexpected output transaction: led_pin=%0b shot_active=%0b",
						out_data.led_pin, out_data.shot_active);
			end else begin
				want = pending_q.pop_front();
				if (out_data.led_pin !== want.led_pin
						|| out_data.shot_active !== want.shot_active) begin
					fail_count++;
					if (fail_count <= SHOW_LIMIT)
						$display("output %0d: expected led_pin=%0b shot_active=%0b, got led_pin=%0b shot_active=%0b",
							result_count, want.led_pin, want.shot_active,
							out_data.led_pin, out_data.shot_active);
				end
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic send_item(input lbps_pkg::in_item_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_count++;
		if (item.op == lbps_pkg::OP_LOAD)
			load_count++;
		pending_q.push_back(led_predict(item));
	endtask

	function automatic lbps_pkg::in_item_t tick_item();
		lbps_pkg::in_item_t item;
		item = '0;
		item.op = lbps_pkg::OP_TICK;
		return item;
	endfunction

	function automatic lbps_pkg::in_item_t load_item(input logic [2:0] count,
			input logic [15:0] a, b, c, d, e, f);
		lbps_pkg::in_item_t item;
		item.op = lbps_pkg::OP_LOAD;
		item.shot_count = count;
		item.dur_a = a;
		item.dur_b = b;
		item.dur_c = c;
		item.dur_d = d;
		item.dur_e = e;
		item.dur_f = f;
		return item;
	endfunction

	task automatic send_ticks(input int n);
		repeat (n)
			send_item(tick_item());
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_q.size() != 0);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		write_count++;
		if (idx == lbps_pkg::REG_MODE) begin
			mode_q = val[2:0];
			if (repeating())
				time_base_q = '0;
			else
				shot_len_q = 0;
		end else if (idx == lbps_pkg::REG_INVERT) begin
			invert_q = val[0];
		end else begin
			rep_dur_q[idx - lbps_pkg::REG_REP_ON1] = val;
		end
	endtask

	task automatic configure(input logic [15:0] mode_word, input logic [15:0] invert_word,
			input logic [15:0] on1, off1, on2, off2, on3, off3);
		logic [5:0][15:0] reps;
		int i;
		reps = {off3, on3, off2, on2, off1, on1};
		settle();
		for (i = 0; i < lbps_pkg::REP_REGS; i++)
			write_reg(lbps_pkg::REG_REP_ON1 + 3'(i), reps[i]);
		write_reg(lbps_pkg::REG_INVERT, invert_word);
		write_reg(lbps_pkg::REG_MODE, mode_word);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] random_duration(input int small_pct);
		int pick;
		pick = $urandom_range(99);
		if (pick < small_pct)
			return 16'($urandom_range(0, 5));
		else if (pick < small_pct + (100 - small_pct) / 3)
			return 16'hFFFF;
		else if (pick < small_pct + 2 * (100 - small_pct) / 3)
			return 16'h0000;
		return 16'($urandom);
	endfunction

	function automatic lbps_pkg::in_item_t random_item();
		lbps_pkg::in_item_t item;
		logic [5:0][15:0] d;
		int i;
		if ($urandom_range(99) < 12) begin
			for (i = 0; i < lbps_pkg::SHOT_FIELDS; i++)
				d[i] = random_duration(92);
			item = load_item(3'($urandom_range(0, 7)), d[0], d[1], d[2], d[3], d[4], d[5]);
		end else begin
			// tick: the unused fields carry noise
			item = lbps_pkg::in_item_t'(IN_BITS'({$urandom, $urandom, $urandom, $urandom}));
			item.op = lbps_pkg::OP_TICK;
		end
		return item;
	endfunction

	task automatic random_configure();
		logic [15:0] mode_word;
		logic [15:0] invert_word;
		logic [5:0][15:0] r;
		int i;
		mode_word = 16'($urandom_range(0, 7));
		if ($urandom_range(1) == 1)
			mode_word = 16'($urandom_range(lbps_pkg::MODE_REP1, lbps_pkg::MODE_REP3));
		if ($urandom_range(1) == 1)
			mode_word[15:3] = 13'($urandom);
		invert_word = 16'($urandom);
		for (i = 0; i < lbps_pkg::REP_REGS; i++)
			r[i] = random_duration(85);
		configure(mode_word, invert_word, r[0], r[1], r[2], r[3], r[4], r[5]);
	endtask

	task automatic test_off_and_invert();
		send_ticks(2);
		configure(16'(lbps_pkg::MODE_OFF), 16'd1, 0, 0, 0, 0, 0, 0);
		send_ticks(1);
		configure(16'(MODE_UNUSED_HI), 16'd0, 0, 0, 0, 0, 0, 0);
		send_ticks(1);
	endtask

	task automatic test_steady_on();
		configure(16'(lbps_pkg::MODE_ON), 16'd0, 0, 0, 0, 0, 0, 0);
		send_ticks(2);
	endtask

	task automatic test_repeat_patterns();
		configure(16'(lbps_pkg::MODE_REP1), 16'd0, 2, 1, 0, 0, 0, 0);
		send_ticks(4);
		configure(16'(lbps_pkg::MODE_REP3), 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF);
		send_ticks(1);
		configure(16'(lbps_pkg::MODE_REP2), 16'd0, 0, 0, 0, 0, 0, 0);
		send_ticks(1);
	endtask

	task automatic test_one_shot();
		configure(16'(lbps_pkg::MODE_REP2), 16'd0, 3, 3, 1, 2, 0, 0);
		send_item(load_item(3'd3, 1, 1, 1, 0, 0, 0));
		send_ticks(5);
		send_item(load_item(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF));
		send_item(load_item(3'd0, 4, 4, 4, 4, 4, 4));
		send_item(load_item(3'd2, 0, 0, 0, 0, 0, 0));
		send_item(load_item(3'd5, 1, 1, 1, 1, 1, 0));
		send_item(load_item(3'd2, 5, 5, 0, 0, 0, 0));
		configure(16'(lbps_pkg::MODE_OFF), 16'd0, 3, 3, 1, 2, 0, 0);
		send_ticks(1);
	endtask

	task automatic test_random_phase(input int send_pct, input int recv_pct, input int total);
		int sent;
		int chunk;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		while (sent < total) begin
			random_configure();
			chunk = $urandom_range(20, 60);
			repeat (chunk)
				send_item(random_item());
			sent += chunk;
		end
	endtask

	initial begin
		mode_q = lbps_pkg::MODE_OFF;
		invert_q = 1'b0;
		rep_dur_q = '0;
		time_base_q = '0;
		shot_marks_q = '0;
		shot_len_q = 0;
		send_idle_pct = 30;
		recv_idle_pct = 50;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_off_and_invert();
		test_steady_on();
		test_repeat_patterns();
		test_one_shot();
		test_random_phase(30, 50, 250);
		test_random_phase(50, 30, 250);
		test_random_phase(0, 0, 250);

		settle();
		repeat (8)
			@(posedge clk);
		if (pending_q.size() != 0) begin
			fail_count += pending_q.size();
			$display("%0d expected output transactions never arrived", pending_q.size());
		end
		$display("covered %0d input transactions (%0d one-shot loads), %0d outputs checked",
			sent_count, load_count, result_count);
		$display("%0d register writes across all modes; %0d failures", write_count, fail_count);
		if (fail_count == 0)
			$display("led_blink_pattern_sequencer: match");
		else
			$display("led_blink_pattern_sequencer: mismatch");
		$finish;
	end

	initial begin
		#6000000;
		$display("timeout: %0d output transactions still expected", pending_q.size());
		$display("led_blink_pattern_sequencer: mismatch");
		$finish;
	end

endmodule
